// ===== design/tlrq_pkg.sv =====
`default_nettype none
package tlrq_pkg;

    localparam int ID_W = 7;
    localparam int CLS_W = 2;
    localparam int CMD_W = 3;
    localparam int ST_W = 2;
    localparam int CNT_W = 8;
    localparam int ENT_W = ID_W + CLS_W;

    localparam logic [CMD_W-1:0] CMD_ENQ = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BLK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RES = 3'd4;

    localparam logic [CLS_W-1:0] CLS_HIGH = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MID = 2'd1;
    localparam logic [CLS_W-1:0] CLS_LOW = 2'd2;
    localparam logic [CLS_W-1:0] CLS_BLK = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  out_id;
        logic [CLS_W-1:0] out_class;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] ready_count;
        logic [CNT_W-1:0] blocked_count;
    } t_result;

endpackage
`default_nettype wire

// ===== design/tlrq_mem.sv =====
`default_nettype none
module tlrq_mem #(
    parameter int AW = 9
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [AW-1:0]              i_rd_addr,
    output logic [tlrq_pkg::ENT_W-1:0]      o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [AW-1:0]              i_wr_addr,
    input  wire logic [tlrq_pkg::ENT_W-1:0] i_wr_data
);

    logic [tlrq_pkg::ENT_W-1:0] r_mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/tlrq_ctrl.sv =====
`default_nettype none
module tlrq_ctrl #(
    parameter int CAPACITY = 128,
    parameter int ID_COUNT = 128
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req_valid,
    output logic                              o_busy,
    input  wire logic [tlrq_pkg::CMD_W-1:0]   i_command,
    input  wire logic [tlrq_pkg::ID_W-1:0]    i_thread_id,
    input  wire logic [1:0]                   i_priority_req,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output tlrq_pkg::t_result                 o_res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int TW = LW + 2;
    localparam int SW = (TW > tlrq_pkg::CNT_W) ? TW : tlrq_pkg::CNT_W;
    localparam int MAW = AW + tlrq_pkg::CLS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_SH_RD = 3'd3;
    localparam logic [2:0] S_SH_WR = 3'd4;
    localparam logic [2:0] S_APP   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                      r_state, n_state;
    logic [tlrq_pkg::CMD_W-1:0]      r_cmd, n_cmd;
    logic [tlrq_pkg::ID_W-1:0]       r_id, n_id;
    logic [tlrq_pkg::CLS_W-1:0]      r_cls, n_cls;
    logic [tlrq_pkg::CLS_W-1:0]      r_dst, n_dst;
    logic [LW-1:0]                   r_pos, n_pos;
    logic [tlrq_pkg::ENT_W-1:0]      r_ent, n_ent;
    logic [tlrq_pkg::ENT_W-1:0]      r_wdata, n_wdata;
    logic [LW-1:0]                   r_len [0:3];
    logic [LW-1:0]                   n_len [0:3];
    logic [tlrq_pkg::ID_W-1:0]       r_res_id, n_res_id;
    logic [tlrq_pkg::CLS_W-1:0]      r_res_cls, n_res_cls;
    logic [tlrq_pkg::ST_W-1:0]       r_res_st, n_res_st;

    logic                            mem_rd_en;
    logic [MAW-1:0]                  mem_rd_addr;
    logic [tlrq_pkg::ENT_W-1:0]      mem_rd_data;
    logic                            mem_wr_en;
    logic [MAW-1:0]                  mem_wr_addr;
    logic [tlrq_pkg::ENT_W-1:0]      mem_wr_data;

    logic [TW-1:0]                   total;
    logic [SW-1:0]                   ready_sum;
    logic [SW-1:0]                   blk_ext;
    logic [LW-1:0]                   next_pos;

    // All four lists share one memory; the class selects the upper address bits.
    tlrq_mem #(.AW(MAW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    assign total = TW'(r_len[0]) + TW'(r_len[1]) + TW'(r_len[2]) + TW'(r_len[3]);
    assign ready_sum = SW'(r_len[0]) + SW'(r_len[1]) + SW'(r_len[2]);
    assign blk_ext = SW'(r_len[3]);
    assign next_pos = r_pos + LW'(1);

    assign o_busy = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res.out_id = r_res_id;
    assign o_res.out_class = r_res_cls;
    assign o_res.status = r_res_st;
    assign o_res.ready_count = ready_sum[tlrq_pkg::CNT_W-1:0];
    assign o_res.blocked_count = blk_ext[tlrq_pkg::CNT_W-1:0];

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_id = r_id;
        n_cls = r_cls;
        n_dst = r_dst;
        n_pos = r_pos;
        n_ent = r_ent;
        n_wdata = r_wdata;
        n_len = r_len;
        n_res_id = r_res_id;
        n_res_cls = r_res_cls;
        n_res_st = r_res_st;
        mem_rd_en = 1'b0;
        mem_rd_addr = {r_cls, r_pos[AW-1:0]};
        mem_wr_en = 1'b0;
        mem_wr_addr = {r_cls, r_pos[AW-1:0]};
        mem_wr_data = mem_rd_data;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cmd = i_command;
                    n_id = i_thread_id;
                    n_pos = '0;
                    n_res_id = '0;
                    n_res_cls = tlrq_pkg::CLS_HIGH;
                    n_res_st = tlrq_pkg::ST_MISS;
                    n_state = S_OUT;
                    case (i_command)
                        tlrq_pkg::CMD_ENQ: begin
                            if (i_priority_req == 2'd0) begin
                                n_dst = tlrq_pkg::CLS_HIGH;
                            end else if (i_priority_req == 2'd1) begin
                                n_dst = tlrq_pkg::CLS_MID;
                            end else begin
                                n_dst = tlrq_pkg::CLS_LOW;
                            end
                            if (32'(i_thread_id) >= 32'(ID_COUNT)) begin
                                n_res_st = tlrq_pkg::ST_MISS;
                            end else if (32'(total) >= 32'(CAPACITY)) begin
                                n_res_st = tlrq_pkg::ST_FULL;
                            end else begin
                                n_wdata = {tlrq_pkg::CLS_HIGH, i_thread_id};
                                n_res_id = i_thread_id;
                                n_res_cls = n_dst;
                                n_res_st = tlrq_pkg::ST_DONE;
                                n_state = S_APP;
                            end
                        end
                        tlrq_pkg::CMD_POP: begin
                            if (r_len[0] != '0) begin
                                n_cls = tlrq_pkg::CLS_HIGH;
                                n_state = S_RD;
                            end else if (r_len[1] != '0) begin
                                n_cls = tlrq_pkg::CLS_MID;
                                n_state = S_RD;
                            end else if (r_len[2] != '0) begin
                                n_cls = tlrq_pkg::CLS_LOW;
                                n_state = S_RD;
                            end
                        end
                        tlrq_pkg::CMD_REM, tlrq_pkg::CMD_BLK: begin
                            n_cls = tlrq_pkg::CLS_HIGH;
                            n_state = S_RD;
                        end
                        tlrq_pkg::CMD_RES: begin
                            n_cls = tlrq_pkg::CLS_BLK;
                            n_state = S_RD;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_RD: begin
                if (r_pos >= r_len[r_cls]) begin
                    if (r_cmd == tlrq_pkg::CMD_RES || r_cls == tlrq_pkg::CLS_LOW) begin
                        n_state = S_OUT;
                    end else begin
                        n_cls = r_cls + 2'd1;
                        n_pos = '0;
                    end
                end else begin
                    mem_rd_en = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_cmd == tlrq_pkg::CMD_POP || mem_rd_data[tlrq_pkg::ID_W-1:0] == r_id) begin
                    n_ent = mem_rd_data;
                    n_state = S_SH_RD;
                end else begin
                    n_pos = next_pos;
                    n_state = S_RD;
                end
            end
            S_SH_RD: begin
                // Close the gap one entry at a time: read the next one, write it down.
                if (next_pos >= r_len[r_cls]) begin
                    n_len[r_cls] = r_len[r_cls] - LW'(1);
                    n_res_st = tlrq_pkg::ST_DONE;
                    n_res_id = r_id;
                    n_res_cls = r_cls;
                    n_state = S_OUT;
                    case (r_cmd)
                        tlrq_pkg::CMD_POP: begin
                            n_res_id = r_ent[tlrq_pkg::ID_W-1:0];
                        end
                        tlrq_pkg::CMD_BLK: begin
                            n_dst = tlrq_pkg::CLS_BLK;
                            n_wdata = {r_cls, r_id};
                            n_state = S_APP;
                        end
                        tlrq_pkg::CMD_RES: begin
                            n_res_cls = tlrq_pkg::CLS_BLK;
                            if (r_ent[tlrq_pkg::ENT_W-1:tlrq_pkg::ID_W] == tlrq_pkg::CLS_BLK) begin
                                n_dst = tlrq_pkg::CLS_LOW;
                            end else begin
                                n_dst = r_ent[tlrq_pkg::ENT_W-1:tlrq_pkg::ID_W];
                            end
                            n_wdata = {tlrq_pkg::CLS_HIGH, r_id};
                            n_state = S_APP;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end else begin
                    mem_rd_en = 1'b1;
                    mem_rd_addr = {r_cls, next_pos[AW-1:0]};
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                mem_wr_en = 1'b1;
                n_pos = next_pos;
                n_state = S_SH_RD;
            end
            S_APP: begin
                mem_wr_en = 1'b1;
                mem_wr_addr = {r_dst, r_len[r_dst][AW-1:0]};
                mem_wr_data = r_wdata;
                n_len[r_dst] = r_len[r_dst] + LW'(1);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len[0] <= '0;
            r_len[1] <= '0;
            r_len[2] <= '0;
            r_len[3] <= '0;
        end else begin
            r_state <= n_state;
            r_len <= n_len;
        end
        r_cmd <= n_cmd;
        r_id <= n_id;
        r_cls <= n_cls;
        r_dst <= n_dst;
        r_pos <= n_pos;
        r_ent <= n_ent;
        r_wdata <= n_wdata;
        r_res_id <= n_res_id;
        r_res_cls <= n_res_cls;
        r_res_st <= n_res_st;
    end

endmodule
`default_nettype wire

// ===== design/three_level_ready_queue_with_block.sv =====
// Sequence: an enqueue goes through the append state to the result; a rejected enqueue, an
// empty pop or an unknown command goes straight to the result; a search followed by a shift
// walks the list one entry at a time, set by the single read port of the list memory.
// Throughput: one request at a time; the next is taken once the result has been registered.
// Reset: synchronous, active low; clears the list lengths and the handshake state.
// List memory contents are not cleared and need no clearing pass.
`default_nettype none
module three_level_ready_queue_with_block #(
    parameter int CAPACITY = 128,
    parameter int ID_COUNT = 128
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [tlrq_pkg::CMD_W-1:0]   i_command,
    input  wire logic [tlrq_pkg::ID_W-1:0]    i_thread_id,
    input  wire logic [1:0]                   i_priority_req,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [tlrq_pkg::ID_W-1:0]         o_out_id,
    output logic [tlrq_pkg::CLS_W-1:0]        o_out_class,
    output logic [tlrq_pkg::ST_W-1:0]         o_status,
    output logic [tlrq_pkg::CNT_W-1:0]        o_ready_count,
    output logic [tlrq_pkg::CNT_W-1:0]        o_blocked_count
);

    logic               busy;
    logic               res_valid;
    logic               res_ready;
    tlrq_pkg::t_result  res;
    logic               r_out_valid;
    tlrq_pkg::t_result  r_out;

    tlrq_ctrl #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_in_valid),
        .o_busy         (busy),
        .i_command      (i_command),
        .i_thread_id    (i_thread_id),
        .i_priority_req (i_priority_req),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    // The output register frees the sequencer while the last result waits.
    assign res_ready = !r_out_valid || !i_out_stall;
    assign o_in_stall = busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_id = r_out.out_id;
    assign o_out_class = r_out.out_class;
    assign o_status = r_out.status;
    assign o_ready_count = r_out.ready_count;
    assign o_blocked_count = r_out.blocked_count;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while sequencer stayed free");

    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != tlrq_pkg::ST_DONE) |-> (o_out_id == '0))
        else $error("failed request reports a thread id");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int CAP = 128;

    typedef struct packed {
        logic [tlrq_pkg::CMD_W-1:0] command;
        logic [tlrq_pkg::ID_W-1:0]  thread_id;
        logic [1:0]                 priority_req;
    } t_request;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic [tlrq_pkg::CMD_W-1:0] i_command;
    logic [tlrq_pkg::ID_W-1:0] i_thread_id;
    logic [1:0] i_priority_req;
    logic o_out_valid;
    logic i_out_stall;
    logic [tlrq_pkg::ID_W-1:0] o_out_id;
    logic [tlrq_pkg::CLS_W-1:0] o_out_class;
    logic [tlrq_pkg::ST_W-1:0] o_status;
    logic [tlrq_pkg::CNT_W-1:0] o_ready_count;
    logic [tlrq_pkg::CNT_W-1:0] o_blocked_count;

    three_level_ready_queue_with_block u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_command(i_command), .i_thread_id(i_thread_id), .i_priority_req(i_priority_req),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_id(o_out_id), .o_out_class(o_out_class), .o_status(o_status),
        .o_ready_count(o_ready_count), .o_blocked_count(o_blocked_count)
    );

    // Scheduler shadow: ready lists indexed by class, blocked entries keep their class.
    logic [tlrq_pkg::ID_W-1:0] ready_q[3][$];
    logic [tlrq_pkg::ENT_W-1:0] blocked_q[$];
    t_request pending_reqs[$];
    tlrq_pkg::t_result expected_results[$];
    int errors = 0;
    int gap_left = 0;
    int stall_left = 0;

    function automatic int find_id(input logic [tlrq_pkg::ID_W-1:0] id, input int cls);
        for (int k = 0; k < ready_q[cls].size(); k++)
            if (ready_q[cls][k] == id) return k;
        return -1;
    endfunction

    function automatic tlrq_pkg::t_result schedule_step(input t_request rq);
        tlrq_pkg::t_result r;
        int total;
        int pos;
        logic [tlrq_pkg::CLS_W-1:0] cls;
        r = '0;
        r.status = tlrq_pkg::ST_MISS;
        total = ready_q[0].size() + ready_q[1].size() + ready_q[2].size() + blocked_q.size();
        case (rq.command)
            tlrq_pkg::CMD_ENQ: begin
                cls = (rq.priority_req == 2'd0) ? tlrq_pkg::CLS_HIGH :
                      (rq.priority_req == 2'd1) ? tlrq_pkg::CLS_MID : tlrq_pkg::CLS_LOW;
                if (total >= CAP) begin
                    r.status = tlrq_pkg::ST_FULL;
                end else begin
                    ready_q[cls].insert(ready_q[cls].size(), rq.thread_id);
                    r.out_id = rq.thread_id;
                    r.out_class = cls;
                    r.status = tlrq_pkg::ST_DONE;
                end
            end
            tlrq_pkg::CMD_POP: begin
                for (int c = 0; c < 3; c++) begin
                    if (ready_q[c].size() > 0) begin
                        r.out_id = ready_q[c].pop_front();
                        r.out_class = tlrq_pkg::CLS_W'(c);
                        r.status = tlrq_pkg::ST_DONE;
                        break;
                    end
                end
            end
            tlrq_pkg::CMD_REM, tlrq_pkg::CMD_BLK: begin
                for (int c = 0; c < 3; c++) begin
                    pos = find_id(rq.thread_id, c);
                    if (pos >= 0) begin
                        ready_q[c].delete(pos);
                        if (rq.command == tlrq_pkg::CMD_BLK)
                            blocked_q.insert(blocked_q.size(),
                                             {tlrq_pkg::CLS_W'(c), rq.thread_id});
                        r.out_id = rq.thread_id;
                        r.out_class = tlrq_pkg::CLS_W'(c);
                        r.status = tlrq_pkg::ST_DONE;
                        break;
                    end
                end
            end
            tlrq_pkg::CMD_RES: begin
                for (int k = 0; k < blocked_q.size(); k++) begin
                    if (blocked_q[k][tlrq_pkg::ID_W-1:0] == rq.thread_id) begin
                        cls = blocked_q[k][tlrq_pkg::ENT_W-1:tlrq_pkg::ID_W];
                        if (cls == tlrq_pkg::CLS_BLK) cls = tlrq_pkg::CLS_LOW;
                        blocked_q.delete(k);
                        ready_q[cls].insert(ready_q[cls].size(), rq.thread_id);
                        r.out_id = rq.thread_id;
                        r.out_class = tlrq_pkg::CLS_BLK;
                        r.status = tlrq_pkg::ST_DONE;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.ready_count = tlrq_pkg::CNT_W'(ready_q[0].size() + ready_q[1].size()
                                         + ready_q[2].size());
        r.blocked_count = tlrq_pkg::CNT_W'(blocked_q.size());
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_request(input logic [tlrq_pkg::CMD_W-1:0] cmd,
                               input logic [tlrq_pkg::ID_W-1:0] id,
                               input logic [1:0] pri);
        t_request rq;
        rq.command = cmd;
        rq.thread_id = id;
        rq.priority_req = pri;
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Driver: holds the request until it is taken, then idles at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            void'(schedule_step_record());
            gap_left = pick_gap();
            if (gap_left == 0 && pending_reqs.size() > 0) load_next();
            else i_in_valid <= 1'b0;
        end else if (!i_in_valid) begin
            if (gap_left > 0) gap_left--;
            else if (pending_reqs.size() > 0) load_next();
        end
    end

    function automatic bit schedule_step_record();
        t_request rq;
        rq = {i_command, i_thread_id, i_priority_req};
        expected_results.insert(expected_results.size(), schedule_step(rq));
        return 1'b1;
    endfunction

    task automatic load_next();
        t_request rq;
        rq = pending_reqs.pop_front();
        i_in_valid <= 1'b1;
        i_command <= rq.command;
        i_thread_id <= rq.thread_id;
        i_priority_req <= rq.priority_req;
    endtask

    // Monitor and receiver stall.
    always @(posedge i_clk) begin
        tlrq_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_id !== want.out_id) begin
                        $error("out_id: expected %0d, got %0d", want.out_id, o_out_id);
                        errors++;
                    end
                    if (o_out_class !== want.out_class) begin
                        $error("out_class: expected %0d, got %0d", want.out_class, o_out_class);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        errors++;
                    end
                    if (o_ready_count !== want.ready_count) begin
                        $error("ready_count: expected %0d, got %0d",
                               want.ready_count, o_ready_count);
                        errors++;
                    end
                    if (o_blocked_count !== want.blocked_count) begin
                        $error("blocked_count: expected %0d, got %0d",
                               want.blocked_count, o_blocked_count);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap();
                i_out_stall <= (stall_left > 0);
            end
        end
    end

    initial begin
        int cmd_pick;
        int id_hi;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_command = '0;
        i_thread_id = '0;
        i_priority_req = '0;
        i_out_stall = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty cases, every class, duplicates, block and resume, bad commands.
        add_request(tlrq_pkg::CMD_POP, 7'd0, 2'd0);
        add_request(tlrq_pkg::CMD_REM, 7'd5, 2'd0);
        add_request(tlrq_pkg::CMD_BLK, 7'd5, 2'd0);
        add_request(tlrq_pkg::CMD_RES, 7'd5, 2'd0);
        add_request(tlrq_pkg::CMD_ENQ, 7'd0, 2'd3);
        add_request(tlrq_pkg::CMD_ENQ, 7'd127, 2'd2);
        add_request(tlrq_pkg::CMD_ENQ, 7'd42, 2'd1);
        add_request(tlrq_pkg::CMD_ENQ, 7'd42, 2'd0);
        add_request(tlrq_pkg::CMD_ENQ, 7'd85, 2'd0);
        add_request(tlrq_pkg::CMD_BLK, 7'd42, 2'd0);
        add_request(tlrq_pkg::CMD_BLK, 7'd127, 2'd0);
        add_request(tlrq_pkg::CMD_RES, 7'd127, 2'd0);
        add_request(tlrq_pkg::CMD_RES, 7'd42, 2'd0);
        add_request(tlrq_pkg::CMD_REM, 7'd42, 2'd0);
        add_request(tlrq_pkg::CMD_REM, 7'd0, 2'd0);
        add_request(3'd5, 7'd85, 2'd0);
        add_request(3'd6, 7'd85, 2'd0);
        add_request(3'd7, 7'd85, 2'd3);
        add_request(tlrq_pkg::CMD_POP, 7'd0, 2'd0);
        add_request(tlrq_pkg::CMD_POP, 7'd0, 2'd0);
        add_request(tlrq_pkg::CMD_POP, 7'd0, 2'd0);
        add_request(tlrq_pkg::CMD_POP, 7'd0, 2'd0);

        // Fill to capacity with a few blocked entries, then overflow.
        for (int k = 0; k < CAP; k++) begin
            add_request(tlrq_pkg::CMD_ENQ, tlrq_pkg::ID_W'($urandom), 2'($urandom));
            if (k % 16 == 0)
                add_request(tlrq_pkg::CMD_BLK, pending_reqs[$].thread_id, 2'd0);
        end
        add_request(tlrq_pkg::CMD_ENQ, 7'd127, 2'd1);
        add_request(tlrq_pkg::CMD_ENQ, 7'd1, 2'd0);

        wait (pending_reqs.size() == 0 && expected_results.size() == 0 && !i_in_valid);
        for (int k = 0; k < CAP + 4; k++) add_request(tlrq_pkg::CMD_POP, 7'd0, 2'd0);
        for (int k = 0; k < 10; k++)
            add_request(tlrq_pkg::CMD_RES, tlrq_pkg::ID_W'($urandom), 2'd0);

        // Random: ids come from a window that is narrow in about half the phases so that searches hit.
        for (int k = 0; k < 1100; k++) begin
            if (k % 275 == 0) id_hi = ($urandom_range(0, 1) != 0) ? 15 : 127;
            cmd_pick = $urandom_range(0, 99);
            if (cmd_pick < 40)
                add_request(tlrq_pkg::CMD_ENQ, tlrq_pkg::ID_W'($urandom_range(0, id_hi)),
                            2'($urandom));
            else if (cmd_pick < 55)
                add_request(tlrq_pkg::CMD_POP, tlrq_pkg::ID_W'($urandom), 2'($urandom));
            else if (cmd_pick < 68)
                add_request(tlrq_pkg::CMD_REM, tlrq_pkg::ID_W'($urandom_range(0, id_hi)),
                            2'($urandom));
            else if (cmd_pick < 82)
                add_request(tlrq_pkg::CMD_BLK, tlrq_pkg::ID_W'($urandom_range(0, id_hi)),
                            2'($urandom));
            else if (cmd_pick < 96)
                add_request(tlrq_pkg::CMD_RES, tlrq_pkg::ID_W'($urandom_range(0, id_hi)),
                            2'($urandom));
            else
                add_request(tlrq_pkg::CMD_W'($urandom_range(5, 7)),
                            tlrq_pkg::ID_W'($urandom), 2'($urandom));
        end

        wait (pending_reqs.size() == 0 && !i_in_valid && expected_results.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (expected_results.size() != 0)
                $error("%0d results never arrived", expected_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
design/tlrq_pkg.sv
design/tlrq_mem.sv
design/tlrq_ctrl.sv
design/three_level_ready_queue_with_block.sv
tb/sv/tb_top.sv
